// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset
`define TCCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/tcce_pkg.sv -----
// Types, codes and helpers for the text console character engine.
// No dependencies; used by the channels, front, queue and back.
package tcce_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_PUT_CHAR   = 2'd0,
      OP_SET_CURSOR = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_READ       = 2'd3
   } opcode_type;

   // Classified command kinds passed from front to back
   typedef enum logic [2:0] {
      CMD_GLYPH,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_TAB,
      CMD_BACKSPACE,
      CMD_SET_CURSOR,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   // One queued command; coordinates already saturated for set cursor
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
      logic [6:0]   column;
      logic [4:0]   row;
      logic         in_range;
   } cmd_type;

   // Control characters
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // Tab stops every eight columns
   localparam int TAB_STEP = 8;

   // Colour reset values and register indexes
   localparam logic [3:0] RESET_FG     = 4'd7;
   localparam logic [3:0] RESET_BG     = 4'd0;
   localparam int         CSR_ADDR_W   = 4;
   localparam logic [3:0] CSR_FG_COLOR = 4'd0;
   localparam logic [3:0] CSR_BG_COLOR = 4'd1;

   localparam int POS_W       = 11;
   localparam int QUEUE_DEPTH = 4;

   // Build a cell word from character and colours
   function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [3:0] fg,
                                             input logic [3:0] bg);
      return {bg, fg, ch};
   endfunction

endpackage

// ----- hdl/tcce_channels.sv -----
// Handshake channel interfaces: request, response and register write.
// Depends on tcce_pkg for the register address width.
interface tcce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_code;
   logic [6:0] column;
   logic [4:0] row;

   modport source (output valid, opcode, char_code, column, row, input ready);
   modport sink (input valid, opcode, char_code, column, row, output ready);
endinterface

interface tcce_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] cursor_pos;
   logic [15:0] cell_word;

   modport source (output valid, cursor_pos, cell_word, input ready);
   modport sink (input valid, cursor_pos, cell_word, output ready);
endinterface

interface tcce_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tcce_pkg::CSR_ADDR_W-1:0]  addr;
   logic [3:0]                       data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ----- hdl/tcce_front.sv -----
// Front end: accepts request words and classifies them into commands.
// Depends on tcce_pkg and tcce_req_if.
module tcce_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   tcce_req_if.sink          req_port,
   input  logic              queue_full,
   input  logic              init_busy,
   output logic              push,
   output tcce_pkg::cmd_type push_cmd
);

   logic       col_fits;
   logic       row_fits;
   logic [6:0] col_sat;
   logic [4:0] row_sat;

   // Take a word whenever the queue has room and the store is ready
   assign req_port.ready = !queue_full && !init_busy;
   assign push           = req_port.valid && req_port.ready;

   // Range checks and saturation against the screen size
   assign col_fits = 32'(req_port.column) < COLUMNS;
   assign row_fits = 32'(req_port.row) < ROWS;
   assign col_sat  = col_fits ? req_port.column : 7'(COLUMNS - 1);
   assign row_sat  = row_fits ? req_port.row : 5'(ROWS - 1);

   // Classification
   always_comb begin
      push_cmd.kind      = tcce_pkg::CMD_GLYPH;
      push_cmd.char_code = req_port.char_code;
      push_cmd.column    = req_port.column;
      push_cmd.row       = req_port.row;
      push_cmd.in_range  = col_fits && row_fits;
      case (tcce_pkg::opcode_type'(req_port.opcode))
         tcce_pkg::OP_PUT_CHAR: begin
            case (req_port.char_code)
               tcce_pkg::CHAR_NEWLINE:   push_cmd.kind = tcce_pkg::CMD_NEWLINE;
               tcce_pkg::CHAR_RETURN:    push_cmd.kind = tcce_pkg::CMD_RETURN;
               tcce_pkg::CHAR_TAB:       push_cmd.kind = tcce_pkg::CMD_TAB;
               tcce_pkg::CHAR_BACKSPACE: push_cmd.kind = tcce_pkg::CMD_BACKSPACE;
               default:                  push_cmd.kind = tcce_pkg::CMD_GLYPH;
            endcase
         end
         tcce_pkg::OP_SET_CURSOR: begin
            push_cmd.kind   = tcce_pkg::CMD_SET_CURSOR;
            push_cmd.column = col_sat;
            push_cmd.row    = row_sat;
         end
         tcce_pkg::OP_CLEAR: push_cmd.kind = tcce_pkg::CMD_CLEAR;
         tcce_pkg::OP_READ:  push_cmd.kind = tcce_pkg::CMD_READ;
         default:            push_cmd.kind = tcce_pkg::CMD_GLYPH;
      endcase
   end

endmodule

// ----- hdl/tcce_queue.sv -----
// Short command queue between front and back ends.
// Depends on tcce_pkg for the command type.
module tcce_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcce_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tcce_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   tcce_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/tcce_back.sv -----
// Back end: cursor, colour registers, cell store, sweeps and the response register.
// Depends on tcce_pkg, tcce_csr_if and tcce_rsp_if.
module tcce_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   tcce_csr_if.sink          csr_port,
   tcce_rsp_if.source        rsp_port,
   input  logic              head_valid,
   input  tcce_pkg::cmd_type head_cmd,
   output logic              head_pop,
   output logic              init_busy
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [COL_W:0]    COLS_C    = (COL_W + 1)'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W:0]    ROWS_R    = (ROW_W + 1)'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W:0]    TAB_INC   = (COL_W + 1)'(tcce_pkg::TAB_STEP);
   localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W + 1)'(tcce_pkg::TAB_STEP - 1));
   localparam logic [15:0]       RESET_BLANK =
      tcce_pkg::make_cell(tcce_pkg::CHAR_SPACE, tcce_pkg::RESET_FG, tcce_pkg::RESET_BG);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCROLL,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [ROW_W-1:0]             top_ff, top_in;
   logic [ADDR_W-1:0]            top_base_ff, top_base_in;
   logic [ADDR_W-1:0]            sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0]            sweep_last_ff, sweep_last_in;
   logic [15:0]                  blank_ff, blank_in;
   logic                         read_hit_ff, read_hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcce_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [15:0]                  rsp_word_ff, rsp_word_in;
   logic [3:0]                   fg_ff, bg_ff;

   logic [15:0]                  cells_mem [CELLS];
   logic [15:0]                  rd_data_ff;
   logic                         mem_wr_en;
   logic [ADDR_W-1:0]            mem_wr_addr;
   logic [15:0]                  mem_wr_data;
   logic                         mem_rd_en;
   logic [ADDR_W-1:0]            mem_rd_addr;

   assign csr_port.ready     = 1'b1;
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.cursor_pos = rsp_pos_ff;
   assign rsp_port.cell_word = rsp_word_ff;
   assign init_busy          = state_ff == S_INIT;
   assign head_pop           = (state_ff == S_IDLE) && head_valid;

   // Colour registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tcce_pkg::RESET_FG;
         bg_ff <= tcce_pkg::RESET_BG;
      end else if (csr_port.valid) begin
         case (csr_port.addr)
            tcce_pkg::CSR_FG_COLOR: fg_ff <= csr_port.data;
            tcce_pkg::CSR_BG_COLOR: bg_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   // Sequencer: one command at a time, rows are kept in a circular order
   always_comb begin
      logic [COL_W-1:0]  sel_col;
      logic [ROW_W-1:0]  sel_row;
      logic [ROW_W:0]    phys_sum;
      logic [ROW_W-1:0]  phys_row;
      logic [ADDR_W-1:0] cell_addr;
      logic [ADDR_W-1:0] cur_lin;
      logic [COL_W:0]    col_w;
      logic [ROW_W:0]    row_w;

      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      top_base_in   = top_base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_last_in = sweep_last_ff;
      blank_in      = blank_ff;
      read_hit_in   = read_hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_word_in   = rsp_word_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = sweep_addr_ff;
      mem_wr_data   = blank_ff;
      mem_rd_en     = 1'b0;

      // Physical address of the cursor, or of the read target
      sel_col  = (head_cmd.kind == tcce_pkg::CMD_READ) ? COL_W'(head_cmd.column) : col_ff;
      sel_row  = (head_cmd.kind == tcce_pkg::CMD_READ) ? ROW_W'(head_cmd.row) : row_ff;
      phys_sum = {1'b0, sel_row} + {1'b0, top_ff};
      phys_row = (phys_sum >= ROWS_R) ? ROW_W'(phys_sum - ROWS_R) : phys_sum[ROW_W-1:0];
      cell_addr   = ADDR_W'(phys_row) * COLS_A + ADDR_W'(sel_col);
      mem_rd_addr = cell_addr;

      // Linear cursor position for the response
      cur_lin = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);

      // Cursor movement for put character
      col_w = {1'b0, col_ff};
      row_w = {1'b0, row_ff};
      case (head_cmd.kind)
         tcce_pkg::CMD_GLYPH:   col_w = col_w + 1'b1;
         tcce_pkg::CMD_NEWLINE: begin
            col_w = '0;
            row_w = row_w + 1'b1;
         end
         tcce_pkg::CMD_RETURN:  col_w = '0;
         tcce_pkg::CMD_TAB:     col_w = (col_w + TAB_INC) & TAB_MASK;
         tcce_pkg::CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               col_w = col_w - 1'b1;
            end else if (row_ff != '0) begin
               col_w = {1'b0, LAST_COL};
               row_w = row_w - 1'b1;
            end
         end
         default: ;
      endcase
      if (col_w >= COLS_C) begin
         col_w = '0;
         row_w = row_w + 1'b1;
      end

      // Response register drains independently
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT, S_SWEEP, S_SCROLL: begin
            mem_wr_en     = 1'b1;
            sweep_addr_in = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (head_valid) begin
               read_hit_in = 1'b0;
               state_in    = S_DONE;
               case (head_cmd.kind)
                  tcce_pkg::CMD_SET_CURSOR: begin
                     col_in = COL_W'(head_cmd.column);
                     row_in = ROW_W'(head_cmd.row);
                  end
                  tcce_pkg::CMD_CLEAR: begin
                     blank_in      = tcce_pkg::make_cell(tcce_pkg::CHAR_SPACE, fg_ff, bg_ff);
                     sweep_addr_in = '0;
                     sweep_last_in = LAST_ADDR;
                     top_in        = '0;
                     top_base_in   = '0;
                     col_in        = '0;
                     row_in        = '0;
                     state_in      = S_SWEEP;
                  end
                  tcce_pkg::CMD_READ: begin
                     mem_rd_en   = head_cmd.in_range;
                     read_hit_in = head_cmd.in_range;
                  end
                  default: begin
                     // Put character, with write at the cursor for a glyph
                     if (head_cmd.kind == tcce_pkg::CMD_GLYPH) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cell_addr;
                        mem_wr_data = tcce_pkg::make_cell(head_cmd.char_code, fg_ff, bg_ff);
                     end
                     col_in = col_w[COL_W-1:0];
                     row_in = row_w[ROW_W-1:0];
                     if (row_w >= ROWS_R) begin
                        // Scroll: old top row becomes the new bottom row
                        row_in        = LAST_ROW;
                        top_in        = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                        top_base_in   = (top_ff == LAST_ROW) ? '0 : top_base_ff + COLS_A;
                        sweep_addr_in = top_base_ff;
                        sweep_last_in = top_base_ff + ROW_SPAN;
                        blank_in      = tcce_pkg::make_cell(tcce_pkg::CHAR_SPACE, fg_ff,
                                                            bg_ff);
                        state_in      = S_SCROLL;
                     end
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = tcce_pkg::POS_W'(cur_lin);
               rsp_word_in  = read_hit_ff ? rd_data_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         top_ff        <= '0;
         top_base_ff   <= '0;
         sweep_addr_ff <= '0;
         sweep_last_ff <= LAST_ADDR;
         blank_ff      <= RESET_BLANK;
         read_hit_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         top_base_ff   <= top_base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         blank_ff      <= blank_in;
         read_hit_ff   <= read_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_pos_ff  <= rsp_pos_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         cells_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= cells_mem[mem_rd_addr];
      end
   end

endmodule

// ----- hdl/text_console_char_engine.sv -----
// Text console engine: queued requests run one at a time, each with a registered response word.
// Scrolling past the bottom row blanks one row through the store write port.
// Clear screen sweeps every cell of the store.
// After reset a clearing pass fills the store with blanks;
// req_port.ready stays low until it ends, register writes are taken throughout.
module text_console_char_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcce_req_if.sink   req_port,
   tcce_rsp_if.source rsp_port,
   tcce_csr_if.sink   csr_port
);

   logic              push;
   tcce_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              queue_empty;
   logic              head_pop;
   tcce_pkg::cmd_type head_cmd;
   logic              init_busy;

   // Classify incoming words
   tcce_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_port   (req_port),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decouple front from back
   tcce_queue #(
      .DEPTH (tcce_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (head_pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   // Execute commands against the cell store
   tcce_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_port   (csr_port),
      .rsp_port   (rsp_port),
      .head_valid (!queue_empty),
      .head_cmd   (head_cmd),
      .head_pop   (head_pop),
      .init_busy  (init_busy)
   );

endmodule

// ----- hdl/tcce_checker.sv -----
// Port-level checks for the text console engine, bound to the top level.
// Depends on assert_macros.svh and the channel interfaces.
`include "assert_macros.svh"

module tcce_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   tcce_req_if.sink   req_port,
   tcce_rsp_if.source rsp_port,
   tcce_csr_if.sink   csr_port
);

   localparam int CELLS = COLUMNS * ROWS;

   logic [3:0] outstanding_ff, outstanding_in;
   logic       req_take;
   logic       rsp_take;
   logic       csr_take;

   assign req_take = req_port.valid && req_port.ready;
   assign rsp_take = rsp_port.valid && rsp_port.ready;
   assign csr_take = csr_port.valid && csr_port.ready;

   // Words accepted but not yet answered
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   `TCCE_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_port.valid, "response after reset")
   `TCCE_ASSERT_ALWAYS(a_init_blocks_req, reset |=> !req_port.ready, "request taken during init")
   `TCCE_ASSERT(a_rsp_hold, rsp_port.valid && !rsp_port.ready |=> rsp_port.valid && $stable(rsp_port.cursor_pos) && $stable(rsp_port.cell_word), "stalled response changed")
   `TCCE_ASSERT(a_rsp_has_req, rsp_port.valid |-> outstanding_ff != 4'd0 || csr_take, "response without request")
   `TCCE_ASSERT(a_pos_range, rsp_port.valid |-> CELLS > 2048 || 32'(rsp_port.cursor_pos) < CELLS, "cursor past screen")

endmodule

bind text_console_char_engine tcce_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcce_checker (
   .clock    (clock),
   .reset    (reset),
   .req_port (req_port),
   .rsp_port (rsp_port),
   .csr_port (csr_port)
);
